// ===== design/rmw_pkg.sv =====
// shared types, constants and tables of the cascaded median / weighted mean filter
package rmw_pkg;

  localparam int NumChan = 3;
  localparam int WinSize = 9;

  localparam logic [5:0] PosLastRow = 6'd32;
  localparam logic [5:0] PosLastCol = 6'd14;
  localparam logic [5:0] PosWinFull = 6'd8;

  typedef enum logic [2:0] {
    OP_LEFT  = 3'b001,
    OP_RIGHT = 3'b010,
    OP_UP    = 3'b100
  } rmw_op_e;

  // one queue word of control: store shift, median write, group end
  typedef struct packed {
    logic       shift;
    logic       wr;
    logic       last;
    logic [3:0] slot;
  } rmw_ctrl_t;

  // compare-exchange pairs of the nine-input median network
  localparam int NumSort   = 19;
  localparam int SortSplit = 9;
  localparam logic [3:0] SortLo [NumSort] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7,
    4'd0, 4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
  };
  localparam logic [3:0] SortHi [NumSort] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8,
    4'd3, 4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
  };
  localparam int MedIdx = 4;

  // serpentine path of a row-start group
  function automatic rmw_op_e row_op(input logic [2:0] seg);
    rmw_op_e op;
    case (seg)
      3'd2, 3'd5: op = OP_UP;
      3'd3, 3'd4: op = OP_RIGHT;
      default:    op = OP_LEFT;
    endcase
    return op;
  endfunction

  function automatic logic [3:0] row_slot(input logic [2:0] seg);
    logic [3:0] s;
    case (seg)
      3'd0:    s = 4'd1;
      3'd1:    s = 4'd2;
      3'd2:    s = 4'd5;
      3'd3:    s = 4'd4;
      3'd4:    s = 4'd3;
      3'd5:    s = 4'd6;
      3'd6:    s = 4'd7;
      default: s = 4'd8;
    endcase
    return s;
  endfunction

endpackage

// ===== design/rmw_pix_if.sv =====
// pixel stream channel
interface rmw_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       row_start;

  modport source(output valid, red_in, green_in, blue_in, row_start, input ready);
  modport sink(input valid, red_in, green_in, blue_in, row_start, output ready);
endinterface

// ===== design/rmw_res_if.sv =====
// filtered pixel result channel
interface rmw_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source(output valid, red_out, green_out, blue_out, input ready);
  modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== design/rmw_queue.sv =====
// two-word queue between window front end and median back end
module rmw_queue #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);
  logic [1:0][Width-1:0] mem_q;
  logic                  wptr_q, rptr_q;
  logic [1:0]            cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
endmodule

// ===== design/rmw_front.sv =====
// front end: group tracking, window loading and serpentine sliding
module rmw_front #(
  parameter int ChanBits = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  rmw_pix_if.sink                                pix_i,
  input  logic                                   full_i,
  output logic                                   push_o,
  output rmw_pkg::rmw_ctrl_t                     ctrl_o,
  output logic [2:0][8:0][ChanBits-1:0]          win_o
);
  import rmw_pkg::*;

  logic [5:0]                          pos_q;
  logic                                mode_q;
  logic [1:0]                          sub_q;
  logic [2:0]                          seg_q;
  logic [2:0][8:0][ChanBits-1:0]       win_q, win_d;
  logic [2:0][ChanBits-1:0]            pix;
  logic [15:0]                         r_ext, g_ext, b_ext;
  logic                                accept, first, mode, complete, is_last;
  logic [5:0]                          last_pos;
  logic [3:0]                          slot, base;
  rmw_op_e                             op;

  assign r_ext  = {8'b0, pix_i.red_in};
  assign g_ext  = {8'b0, pix_i.green_in};
  assign b_ext  = {8'b0, pix_i.blue_in};
  assign pix[0] = r_ext[ChanBits-1:0];
  assign pix[1] = g_ext[ChanBits-1:0];
  assign pix[2] = b_ext[ChanBits-1:0];

  assign pix_i.ready = !full_i;
  assign accept      = pix_i.valid && pix_i.ready;

  assign first    = pos_q == 6'd0;
  assign mode     = first ? pix_i.row_start : mode_q;
  assign last_pos = mode ? PosLastRow : PosLastCol;
  assign is_last  = pos_q == last_pos;
  assign op       = mode ? row_op(seg_q) : OP_UP;
  assign base     = {2'b0, sub_q} + {1'b0, sub_q, 1'b0};

  always_comb begin
    win_d    = win_q;
    complete = 1'b0;
    slot     = mode ? 4'd0 : 4'd2;
    if (pos_q <= PosWinFull) begin
      for (int ch = 0; ch < NumChan; ch++) begin
        win_d[ch][pos_q[3:0]] = pix[ch];
      end
      complete = pos_q == PosWinFull;
    end else begin
      slot     = mode ? row_slot(seg_q) : (seg_q[0] ? 4'd8 : 4'd5);
      complete = sub_q == 2'd2;
      for (int ch = 0; ch < NumChan; ch++) begin
        case (op)
          OP_LEFT: begin
            win_d[ch][base]        = win_q[ch][base + 4'd1];
            win_d[ch][base + 4'd1] = win_q[ch][base + 4'd2];
            win_d[ch][base + 4'd2] = pix[ch];
          end
          OP_RIGHT: begin
            win_d[ch][base + 4'd2] = win_q[ch][base + 4'd1];
            win_d[ch][base + 4'd1] = win_q[ch][base];
            win_d[ch][base]        = pix[ch];
          end
          OP_UP: begin
            // rows move up once, on the first pixel of the step
            if (sub_q == 2'd0) begin
              for (int c = 0; c < 3; c++) begin
                win_d[ch][c]     = win_q[ch][c + 3];
                win_d[ch][c + 3] = win_q[ch][c + 6];
              end
            end
            win_d[ch][4'd6 + {2'b0, sub_q}] = pix[ch];
          end
          default: win_d[ch] = win_q[ch];
        endcase
      end
    end
  end

  assign ctrl_o.shift = first && !mode;
  assign ctrl_o.wr    = complete;
  assign ctrl_o.last  = is_last;
  assign ctrl_o.slot  = slot;
  assign win_o        = win_d;
  assign push_o       = accept && (ctrl_o.shift || complete);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 6'd0;
      mode_q <= 1'b0;
      sub_q  <= 2'd0;
      seg_q  <= 3'd0;
      win_q  <= '0;
    end else if (accept) begin
      win_q <= win_d;
      if (first) begin
        mode_q <= mode;
      end
      if (is_last) begin
        pos_q <= 6'd0;
        sub_q <= 2'd0;
        seg_q <= 3'd0;
      end else begin
        pos_q <= pos_q + 6'd1;
        if (pos_q > PosWinFull) begin
          sub_q <= (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
          if (sub_q == 2'd2) begin
            seg_q <= seg_q + 3'd1;
          end
        end
      end
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLastRow) else $error("group position out of range");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!mode_q && pos_q != 6'd0) |-> pos_q <= PosLastCol) else $error("column group overrun");
  a_sub_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= 6'd9) |-> (sub_q == 2'd0 && seg_q == 3'd0)) else $error("step counter out of sync");
endmodule

// ===== design/rmw_back.sv =====
// back end: median network, median store, weighted sum and divide by ten
module rmw_back #(
  parameter int ChanBits = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  rmw_pkg::rmw_ctrl_t            ctrl_i,
  input  logic [2:0][8:0][ChanBits-1:0] win_i,
  output logic                          pop_o,
  rmw_res_if.source                     res_o
);
  import rmw_pkg::*;

  localparam int SumBits = ChanBits + 4;
  localparam int K       = SumBits + 4;
  localparam logic [K-1:0] Recip = K'((64'd1 << K) / 64'd10);

  logic                          adv;
  logic                          v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;
  rmw_ctrl_t                     c1_q, c2_q;
  logic [2:0][8:0][ChanBits-1:0] w1_q, w1_d, w2_t;
  logic [2:0][ChanBits-1:0]      med_q, med_d;
  logic [2:0][8:0][ChanBits-1:0] store_q, store_d;
  logic [2:0][SumBits-1:0]       sum_q, sum_d, sum5_q, qe_q, qe_d, q_d;
  logic [2:0][SumBits-1:0]       rem;
  logic [2:0][SumBits+K-1:0]     prod;
  logic [2:0][7:0]               out_q;

  assign adv   = !ov_q || res_o.ready;
  assign pop_o = adv && !empty_i;

  // first half of the median network: the three rows get sorted
  always_comb begin
    logic [ChanBits-1:0] lo, hi;
    w1_d = win_i;
    for (int ch = 0; ch < NumChan; ch++) begin
      for (int k = 0; k < SortSplit; k++) begin
        lo = w1_d[ch][SortLo[k]];
        hi = w1_d[ch][SortHi[k]];
        if (lo > hi) begin
          w1_d[ch][SortLo[k]] = hi;
          w1_d[ch][SortHi[k]] = lo;
        end
      end
    end
  end

  always_comb begin
    logic [ChanBits-1:0] lo, hi;
    w2_t = w1_q;
    for (int ch = 0; ch < NumChan; ch++) begin
      for (int k = SortSplit; k < NumSort; k++) begin
        lo = w2_t[ch][SortLo[k]];
        hi = w2_t[ch][SortHi[k]];
        if (lo > hi) begin
          w2_t[ch][SortLo[k]] = hi;
          w2_t[ch][SortHi[k]] = lo;
        end
      end
      med_d[ch] = w2_t[ch][MedIdx];
    end
  end

  // column groups shift the store left before their medians land
  always_comb begin
    store_d = store_q;
    for (int ch = 0; ch < NumChan; ch++) begin
      if (c2_q.shift) begin
        for (int r = 0; r < 3; r++) begin
          store_d[ch][r*3]     = store_q[ch][r*3 + 1];
          store_d[ch][r*3 + 1] = store_q[ch][r*3 + 2];
        end
      end
      if (c2_q.wr) begin
        store_d[ch][c2_q.slot] = med_q[ch];
      end
    end
  end

  // center counts twice
  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      sum_d[ch] = ((SumBits'(store_q[ch][0]) + SumBits'(store_q[ch][1]))
                 + (SumBits'(store_q[ch][2]) + SumBits'(store_q[ch][3])))
                + ((SumBits'(store_q[ch][4]) + SumBits'(store_q[ch][4]))
                 + (SumBits'(store_q[ch][5]) + SumBits'(store_q[ch][6])))
                + (SumBits'(store_q[ch][7]) + SumBits'(store_q[ch][8]));
      prod[ch]  = (SumBits+K)'(sum_q[ch]) * (SumBits+K)'(Recip);
      qe_d[ch]  = prod[ch][SumBits+K-1:K];
      // estimate is low by at most one
      rem[ch]   = sum5_q[ch] - ((qe_q[ch] << 3) + (qe_q[ch] << 1));
      q_d[ch]   = (rem[ch] >= SumBits'(10)) ? qe_q[ch] + SumBits'(1) : qe_q[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q   <= ctrl_i;
      w1_q   <= w1_d;
      c2_q   <= c1_q;
      med_q  <= med_d;
      sum_q  <= sum_d;
      sum5_q <= sum_q;
      qe_q   <= qe_d;
      for (int ch = 0; ch < NumChan; ch++) begin
        out_q[ch] <= q_d[ch][7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      ov_q    <= 1'b0;
      store_q <= '0;
    end else if (adv) begin
      v1_q <= !empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q && c2_q.last;
      v4_q <= v3_q;
      v5_q <= v4_q;
      ov_q <= v5_q;
      if (v2_q) begin
        store_q <= store_d;
      end
    end
  end

  assign res_o.valid     = ov_q;
  assign res_o.red_out   = out_q[0];
  assign res_o.green_out = out_q[1];
  assign res_o.blue_out  = out_q[2];

  a_last_has_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && c2_q.last) |-> c2_q.wr) else $error("group end without median write");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && c2_q.wr) |-> c2_q.slot <= 4'd8) else $error("median slot out of range");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v5_q) && $stable(v4_q)) else $error("pipeline moved while stalled");
endmodule

// ===== design/rgb_median_then_weighted_mean_3x3.sv =====
// top level of the cascaded 3x3 median and weighted mean rgb filter
//
//  channel | dir | word                              | handshake
//  pix_i   | in  | red_in, green_in, blue_in, row_start | valid / ready
//  res_o   | out | red_out, green_out, blue_out         | valid / ready
//
// one pixel a cycle while the queue is not full; a group of 33 (row start) or 15 (column) pixels gives one result
// after the queue, the result of a group passes six back-end stages:
// (two median-network halves, store update, sum, reciprocal multiply, correction)
// a two-word queue parts the window front end from the back end; a held result
// stalls the back end and the front end stops only when the queue is full
// asynchronous active-low reset clears window, store and group position
module rgb_median_then_weighted_mean_3x3 #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmw_pix_if.sink    pix_i,
  rmw_res_if.source  res_o
);
  import rmw_pkg::*;

  localparam int WinBits = 27 * CHANNEL_BITS;
  localparam int QBits   = $bits(rmw_ctrl_t) + WinBits;

  logic                              push, pop, full, empty;
  rmw_ctrl_t                         f_ctrl, b_ctrl;
  logic [2:0][8:0][CHANNEL_BITS-1:0] f_win, b_win;
  logic [QBits-1:0]                  q_out;

  rmw_front #(.ChanBits(CHANNEL_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .full_i (full),
    .push_o (push),
    .ctrl_o (f_ctrl),
    .win_o  (f_win)
  );

  rmw_queue #(.Width(QBits)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_ctrl, f_win}),
    .pop_i   (pop),
    .data_o  (q_out),
    .full_o  (full),
    .empty_o (empty)
  );

  assign b_ctrl = q_out[QBits-1:WinBits];
  assign b_win  = q_out[WinBits-1:0];

  rmw_back #(.ChanBits(CHANNEL_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .ctrl_i  (b_ctrl),
    .win_i   (b_win),
    .pop_o   (pop),
    .res_o   (res_o)
  );
endmodule

// ===== test/rmw_tb_if.sv =====
// testbench copies of the pixel and result channels are not needed; this file holds stream helpers
`timescale 1ns / 100ps
package rmw_tb_pkg;
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_start;
  } pix_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_word_t;
endpackage

// ===== test/rgb_median_then_weighted_mean_3x3_tb.sv =====
// self-checking testbench of the cascaded 3x3 median and weighted mean rgb filter
`timescale 1ns / 100ps
module rgb_median_then_weighted_mean_3x3_tb;
  import rmw_pkg::*;
  import rmw_tb_pkg::*;

  localparam int NumRandGroups = 80;
  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  rmw_pix_if pix_if();
  rmw_res_if res_if();

  rgb_median_then_weighted_mean_3x3 dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .pix_i(pix_if.sink), .res_o(res_if.source)
  );

  // predictor state
  logic [7:0] win_q [3][9];
  logic [7:0] med_q [3][9];
  int unsigned grp_pos;
  logic grp_row;

  rgb_word_t filtered_q[$];
  pix_word_t pixel_q[$];
  logic      chk_q[$];       // 1: check against fixed value in fixed_q
  rgb_word_t fixed_q[$];
  int errors = 0;
  int n_pix = 0, n_res = 0, n_row = 0, n_col = 0;
  bit stim_done = 0;
  bit hold_off = 0;

  function automatic logic [7:0] median9(input logic [7:0] v [9]);
    logic [7:0] s [9];
    logic [7:0] t;
    s = v;
    for (int i = 0; i < 9; i++)
      for (int j = 0; j < 8 - i; j++)
        if (s[j] > s[j+1]) begin
          t = s[j]; s[j] = s[j+1]; s[j+1] = t;
        end
    return s[4];
  endfunction

  function automatic void window_move(int ch, rmw_op_e op, int sub, logic [7:0] px);
    int r;
    r = sub * 3;
    case (op)
      OP_LEFT: begin
        win_q[ch][r] = win_q[ch][r+1]; win_q[ch][r+1] = win_q[ch][r+2];
        win_q[ch][r+2] = px;
      end
      OP_RIGHT: begin
        win_q[ch][r+2] = win_q[ch][r+1]; win_q[ch][r+1] = win_q[ch][r];
        win_q[ch][r] = px;
      end
      default: begin
        if (sub == 0)
          for (int c = 0; c < 3; c++) begin
            win_q[ch][c] = win_q[ch][3+c]; win_q[ch][3+c] = win_q[ch][6+c];
          end
        win_q[ch][6+sub] = px;
      end
    endcase
  endfunction

  // advance the filter model by one pixel; returns 1 with the filtered word at group end
  function automatic bit filter_pixel(input pix_word_t w, output rgb_word_t res);
    logic [7:0] px [3];
    int unsigned p, last, seg, sub, slot, sum;
    bit done;
    rmw_op_e op;
    px[0] = w.red; px[1] = w.green; px[2] = w.blue;
    p = grp_pos; done = 0; slot = 0;
    res = '0;
    if (p == 0) begin
      grp_row = w.row_start;
      if (!grp_row)
        for (int ch = 0; ch < 3; ch++)
          for (int r = 0; r < 3; r++) begin
            med_q[ch][r*3] = med_q[ch][r*3+1];
            med_q[ch][r*3+1] = med_q[ch][r*3+2];
          end
    end
    last = grp_row ? PosLastRow : PosLastCol;
    if (p < 9) begin
      for (int ch = 0; ch < 3; ch++) win_q[ch][p] = px[ch];
      done = (p == 8);
      slot = grp_row ? 0 : 2;
    end else begin
      seg = (p - 9) / 3; sub = (p - 9) % 3;
      if (grp_row) begin
        op = row_op(seg[2:0]); slot = row_slot(seg[2:0]);
      end else begin
        op = OP_UP; slot = seg[0] ? 8 : 5;
      end
      for (int ch = 0; ch < 3; ch++) window_move(ch, op, sub, px[ch]);
      done = (sub == 2);
    end
    if (done)
      for (int ch = 0; ch < 3; ch++) med_q[ch][slot] = median9(win_q[ch]);
    if (p == last) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum = 0;
        for (int k = 0; k < 9; k++) sum += med_q[ch][k];
        sum += med_q[ch][4];
        case (ch)
          0: res.red = 8'(sum / 10);
          1: res.green = 8'(sum / 10);
          default: res.blue = 8'(sum / 10);
        endcase
      end
      grp_pos = 0;
      if (grp_row) n_row++; else n_col++;
      return 1;
    end
    grp_pos = p + 1;
    return 0;
  endfunction

  // directed table: one row per group, flat color or random fill, with the expected word where obvious
  typedef struct {
    bit        row;
    logic [7:0] r, g, b;
    bit        rand_fill;   // random pixels; row_start noise on later pixels is in every group
    bit        fixed;
    rgb_word_t want;
  } group_row_t;

  group_row_t dir_tbl [10] = '{
    '{1'b0, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1, '{8'd76, 8'd76, 8'd76}},  // column before any row group
    '{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{1'b1, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd178, 8'd178, 8'd178}},
    '{1'b1, 8'haa, 8'h55, 8'h0f, 1'b0, 1'b1, '{8'haa, 8'h55, 8'h0f}},
    '{1'b1, 8'h55, 8'haa, 8'hf0, 1'b0, 1'b1, '{8'h55, 8'haa, 8'hf0}},
    '{1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '0}
  };

  task automatic queue_group(input bit row, input int kind, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
    pix_word_t w;
    int len;
    len = row ? 33 : 15;
    for (int i = 0; i < len; i++) begin
      w.row_start = (i == 0) ? row : 1'($urandom);
      case (kind)
        0: begin w.red = r; w.green = g; w.blue = b; end
        1: begin w.red = 8'($urandom); w.green = 8'($urandom); w.blue = 8'($urandom); end
        default: begin  // narrow band around a level so medians vary smoothly
          w.red = r + 8'($urandom_range(0, 15)); w.green = g + 8'($urandom_range(0, 15));
          w.blue = b + 8'($urandom_range(0, 15));
        end
      endcase
      pixel_q.push_back(w);
    end
  endtask

  // sender: bursts and gaps
  initial begin
    int burst;
    pix_if.valid <= 1'b0;
    pix_if.red_in <= '0; pix_if.green_in <= '0; pix_if.blue_in <= '0;
    pix_if.row_start <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int t = 0; t < 10; t++)
      queue_group(dir_tbl[t].row, dir_tbl[t].rand_fill ? 1 : 0,
                  dir_tbl[t].r, dir_tbl[t].g, dir_tbl[t].b);
    for (int t = 0; t < NumRandGroups; t++)
      queue_group($urandom_range(0, 2) == 0, $urandom_range(0, 2),
                  8'($urandom), 8'($urandom), 8'($urandom));
    burst = 0;
    while (pixel_q.size() > 0) begin
      if (burst == 0 && $urandom_range(0, 3) == 0) begin
        pix_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst = $urandom_range(1, 40);
      end
      pix_if.valid <= 1'b1;
      {pix_if.red_in, pix_if.green_in, pix_if.blue_in, pix_if.row_start} <= pixel_q[0];
      @(posedge clk_i);
      while (!pix_if.ready) @(posedge clk_i);
      void'(pixel_q.pop_front());
      if (burst > 0) burst--;
    end
    pix_if.valid <= 1'b0;
    stim_done = 1;
  end

  // predict on every accepted pixel
  int grp_idx = 0;
  always @(posedge clk_i) begin
    rgb_word_t res;
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      n_pix++;
      if (filter_pixel({pix_if.red_in, pix_if.green_in, pix_if.blue_in, pix_if.row_start},
                       res)) begin
        filtered_q.push_back(res);
        if (grp_idx < 10 && dir_tbl[grp_idx].fixed) begin
          chk_q.push_back(1'b1); fixed_q.push_back(dir_tbl[grp_idx].want);
        end else begin
          chk_q.push_back(1'b0); fixed_q.push_back('0);
        end
        grp_idx++;
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (n_pix > 300 && !hold_off && n_res < 30) begin
        hold_off = 1;
        res_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      res_if.ready <= (n_pix / 200) % 2 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // compare results
  always @(posedge clk_i) begin
    rgb_word_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      n_res++;
      if (filtered_q.size() == 0) begin
        $error("result with none expected: %h %h %h",
               res_if.red_out, res_if.green_out, res_if.blue_out);
        errors++;
      end else begin
        want = filtered_q.pop_front();
        if (chk_q.pop_front() && fixed_q[0] != want) begin
          $error("predictor disagrees with table: table %h model %h", fixed_q[0], want);
          errors++;
        end
        void'(fixed_q.pop_front());
        if (res_if.red_out !== want.red) begin
          $error("red_out: expected %0d, actual %0d", want.red, res_if.red_out); errors++;
        end
        if (res_if.green_out !== want.green) begin
          $error("green_out: expected %0d, actual %0d", want.green, res_if.green_out); errors++;
        end
        if (res_if.blue_out !== want.blue) begin
          $error("blue_out: expected %0d, actual %0d", want.blue, res_if.blue_out); errors++;
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    int idle;
    idle = 0;
    wait (stim_done);
    // let the predictor take the last accepted pixel first
    @(posedge clk_i);
    while (filtered_q.size() > 0 && idle < IdleLimit) begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) idle = 0; else idle++;
    end
    repeat (20) @(posedge clk_i);
    $display("%0d pixels in %0d row-start and %0d column groups, %0d words checked",
             n_pix, n_row, n_col, n_res);
    if (idle >= IdleLimit || errors != 0 || filtered_q.size() != 0) begin
      if (filtered_q.size() != 0) $error("%0d words never arrived", filtered_q.size());
      $display("== FAIL ==");
    end else begin
      $display("== PASS ==");
    end
    $finish;
  end

  initial begin
    int idle;
    idle = 0;
    wait (rst_ni);
    while (!stim_done) begin
      @(posedge clk_i);
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end
endmodule

// ===== rgb_median_then_weighted_mean_3x3.f =====
design/rmw_pkg.sv
design/rmw_pix_if.sv
design/rmw_res_if.sv
design/rmw_queue.sv
design/rmw_front.sv
design/rmw_back.sv
design/rgb_median_then_weighted_mean_3x3.sv
test/rmw_tb_if.sv
test/rgb_median_then_weighted_mean_3x3_tb.sv
